@@ sv/vcsp_pkg.sv @@
// shared types and constants of the command stream parser
// used by vcsp_front, vcsp_queue, vcsp_back, the top level and the bench; no dependencies
package vcsp_pkg;

    // command bytes
    localparam logic [7:0] CMD_WRITE_P0   = 8'h52;
    localparam logic [7:0] CMD_WRITE_P1   = 8'h53;
    localparam logic [7:0] CMD_WAIT_N     = 8'h61;
    localparam logic [7:0] CMD_END        = 8'h66;
    localparam logic [7:0] CMD_DATA_BLOCK = 8'h67;
    localparam logic [7:0] CMD_SEEK       = 8'hE0;
    localparam logic [3:0] GRP_WAIT_SHORT = 4'h7;
    localparam logic [3:0] GRP_PCM_SEND   = 4'h8;
    localparam logic [7:0] REG_PCM_DATA   = 8'h2A;

    // work kinds handed from front to back
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_EMIT  = 3'd1;
    localparam logic [2:0] K_SEND  = 3'd2;
    localparam logic [2:0] K_SEEK  = 3'd3;
    localparam logic [2:0] K_BLKCL = 3'd4;
    localparam logic [2:0] K_DATA  = 3'd5;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_stream;
    } t_in;

    typedef struct packed {
        logic        has_write;
        logic        port;
        logic [7:0]  reg_addr;
        logic [7:0]  reg_value;
        logic [15:0] wait_samples;
        logic        stream_end;
        logic        bad_command;
    } t_out;

    typedef struct packed {
        logic        clr;
        logic [2:0]  kind;
        logic [31:0] arg;
        t_out        res;
    } t_qent;

endpackage

@@ sv/vgm_command_stream_parser.sv @@
// top level of the command stream parser: front end, work queue, back end
// depends on vcsp_pkg, vcsp_front, vcsp_queue and vcsp_back
//
// Takes one command stream byte per request and returns at most one result per
// byte: chip register writes (0x52/0x53), waits (0x61, 0x7n), pcm sends (0x8n,
// port 0 register 0x2A), end of stream (0x66) and unknown commands. Data blocks
// (0x67) and seeks (0xE0) update the pcm block and read offset silently. After
// an end or an unknown command every byte is dropped until start_of_stream is
// set. While the queue has room and the output is not stalled, throughput is one
// byte per clock on both sides: the front end parses one byte per cycle, the back
// end retires one queued work item per cycle with a single write and a single
// read on the pcm memory. The edge that takes the last byte of a command writes
// the queue; from there the work moves into the memory read stage and then into
// the output register, and a stall can hold it in the queue or either register.
// The queue holds QUEUE_DEPTH items so a stalled output does not immediately
// stop the input; the input ready drops only when it fills.
// The pcm memory needs no clearing: only entries written by the current block
// are ever read, so the block is ready right out of reset.
module vgm_command_stream_parser
    import vcsp_pkg::*;
#(
    parameter int PCM_DEPTH   = 65536,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_ready,
    output logic o_valid,
    output t_out o_data,
    input  logic i_ready
);

    // front to queue
    logic  front_push;
    t_qent front_ent;
    logic  q_full;

    // queue to back
    logic  q_valid;
    t_qent q_ent;
    logic  back_pop;

    // byte parser, one request per cycle while the queue has room
    vcsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (o_ready),
        .i_full  (q_full),
        .o_push  (front_push),
        .o_ent   (front_ent)
    );

    // decouples parsing from pcm memory access and output stalls
    vcsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_ent   (front_ent),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (back_pop)
    );

    // pcm memory, read pointer and result register
    vcsp_back #(
        .PCM_DEPTH (PCM_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_pop     (back_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_ready   (i_ready)
    );

endmodule

@@ sv/vcsp_front.sv @@
// front end: takes stream bytes, gathers operands and classifies commands
// depends on vcsp_pkg
module vcsp_front
    import vcsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_ready,
    input  logic  i_full,
    output logic  o_push,
    output t_qent o_ent
);

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_OPS  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]  r_phase, n_phase, e_phase;
    logic [2:0]  r_cnt, n_cnt, e_cnt;
    logic [31:0] r_acc, n_acc, e_acc;
    logic [7:0]  r_cmd, n_cmd, e_cmd;
    logic        r_halted, n_halted, e_halted;

    logic        accept;
    logic        sos;
    logic [7:0]  b;
    logic [2:0]  need;
    logic [2:0]  cnt_inc;
    logic [1:0]  sh;
    logic        take;
    logic [31:0] acc_or;
    t_qent       ent;

    function automatic logic [2:0] ops_needed(input logic [7:0] cmd);
        logic [2:0] n;
        n = 3'd0;
        if (cmd == CMD_WRITE_P0 || cmd == CMD_WRITE_P1 || cmd == CMD_WAIT_N) begin
            n = 3'd2;
        end else if (cmd == CMD_SEEK) begin
            n = 3'd4;
        end else if (cmd == CMD_DATA_BLOCK) begin
            n = 3'd6;
        end
        return n;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign sos     = i_data.start_of_stream;
    assign b       = i_data.stream_byte;

    always_comb begin
        // start of stream clears the parser before the byte is taken
        e_phase  = sos ? PH_CMD : r_phase;
        e_cnt    = sos ? 3'd0 : r_cnt;
        e_acc    = sos ? 32'd0 : r_acc;
        e_cmd    = sos ? 8'd0 : r_cmd;
        e_halted = sos ? 1'b0 : r_halted;

        n_phase  = e_phase;
        n_cnt    = e_cnt;
        n_acc    = e_acc;
        n_cmd    = e_cmd;
        n_halted = e_halted;

        ent      = '0;
        ent.clr  = sos;
        ent.kind = K_NONE;

        need    = ops_needed(e_cmd);
        cnt_inc = e_cnt + 3'd1;
        if (e_cmd == CMD_DATA_BLOCK) begin
            // marker and type bytes are skipped, size starts at the third operand
            take = (e_cnt >= 3'd2);
            sh   = 2'(e_cnt - 3'd2);
        end else begin
            take = 1'b1;
            sh   = e_cnt[1:0];
        end
        acc_or = e_acc | (take ? (32'(b) << {sh, 3'b000}) : 32'd0);

        if (!e_halted) begin
            unique case (e_phase)
                PH_CMD: begin
                    n_cmd = b;
                    n_cnt = 3'd0;
                    n_acc = 32'd0;
                    if (ops_needed(b) != 3'd0) begin
                        n_phase = PH_OPS;
                    end else if (b == CMD_END) begin
                        ent.kind           = K_EMIT;
                        ent.res.stream_end = 1'b1;
                        n_halted           = 1'b1;
                    end else if (b[7:4] == GRP_WAIT_SHORT) begin
                        ent.kind             = K_EMIT;
                        ent.res.wait_samples = 16'(b[3:0]) + 16'd1;
                    end else if (b[7:4] == GRP_PCM_SEND) begin
                        ent.kind             = K_SEND;
                        ent.res.wait_samples = 16'(b[3:0]);
                    end else begin
                        ent.kind            = K_EMIT;
                        ent.res.bad_command = 1'b1;
                        n_halted            = 1'b1;
                    end
                end
                PH_OPS: begin
                    n_acc = acc_or;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= need) begin
                        n_phase = PH_CMD;
                        n_cnt   = 3'd0;
                        if (e_cmd == CMD_WRITE_P0 || e_cmd == CMD_WRITE_P1) begin
                            ent.kind          = K_EMIT;
                            ent.res.has_write = 1'b1;
                            ent.res.port      = e_cmd[0];
                            ent.res.reg_addr  = acc_or[7:0];
                            ent.res.reg_value = acc_or[15:8];
                        end else if (e_cmd == CMD_WAIT_N) begin
                            ent.kind             = K_EMIT;
                            ent.res.wait_samples = acc_or[15:0];
                        end else if (e_cmd == CMD_SEEK) begin
                            ent.kind = K_SEEK;
                            ent.arg  = acc_or;
                        end else begin
                            // data block header done: drop the old block
                            ent.kind = K_BLKCL;
                            if (acc_or != 32'd0) begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    ent.kind = K_DATA;
                    ent.arg  = 32'(b);
                    n_acc    = e_acc - 32'd1;
                    if (n_acc == 32'd0) begin
                        n_phase = PH_CMD;
                    end
                end
                default: begin
                    n_phase = PH_CMD;
                end
            endcase
        end
    end

    assign o_push = accept && (ent.clr || ent.kind != K_NONE);
    assign o_ent  = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CMD;
            r_cnt    <= 3'd0;
            r_acc    <= 32'd0;
            r_cmd    <= 8'd0;
            r_halted <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_cmd    <= n_cmd;
            r_halted <= n_halted;
        end
    end

    // a halted parser hands nothing on until the next start of stream
    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_halted && !sos) |-> !o_push)
        else $error("halted parser pushed work");

endmodule

@@ sv/vcsp_queue.sv @@
// short fifo of classified work between front and back
// depends on vcsp_pkg
module vcsp_queue
    import vcsp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_ent,
    input  logic  i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_qent         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_ent   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("queue count beyond depth");

endmodule

@@ sv/vcsp_back.sv @@
// back end: pcm block memory, read pointer and the result register
// depends on vcsp_pkg
module vcsp_back
    import vcsp_pkg::*;
#(
    parameter int PCM_DEPTH = 65536
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_qent i_q_ent,
    output logic  o_pop,
    output logic  o_valid,
    output t_out  o_data,
    input  logic  i_ready
);

    localparam int AW = $clog2(PCM_DEPTH);
    localparam int SW = $clog2(PCM_DEPTH + 1);
    localparam logic [SW-1:0] DEPTH_W = SW'(PCM_DEPTH);

    logic [7:0]    r_pcm [PCM_DEPTH];
    logic [7:0]    r_rd;

    logic [SW-1:0] r_size, n_size, e_size;
    logic [SW-1:0] r_pos, n_pos, e_pos;

    logic          r_p_valid;
    t_out          r_p_res;
    logic          r_p_mem;
    logic          r_o_valid;
    t_out          r_o_res;

    logic          p_move;
    logic          p_free;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic          p_load;
    t_out          p_res;
    t_out          o_res;

    assign p_move = r_p_valid && (!r_o_valid || i_ready);
    assign p_free = !r_p_valid || p_move;
    assign o_pop  = i_q_valid && p_free;

    always_comb begin
        e_size = i_q_ent.clr ? '0 : r_size;
        e_pos  = i_q_ent.clr ? '0 : r_pos;
        n_size = e_size;
        n_pos  = e_pos;
        we     = 1'b0;
        waddr  = e_size[AW-1:0];
        wdata  = i_q_ent.arg[7:0];
        re     = 1'b0;
        raddr  = e_pos[AW-1:0];
        p_load = 1'b0;
        p_res  = i_q_ent.res;

        unique case (i_q_ent.kind)
            K_EMIT: begin
                p_load = 1'b1;
            end
            K_SEND: begin
                p_load = 1'b1;
                if (e_pos < e_size) begin
                    re              = 1'b1;
                    n_pos           = e_pos + SW'(1);
                    p_res.has_write = 1'b1;
                    p_res.port      = 1'b0;
                    p_res.reg_addr  = REG_PCM_DATA;
                end
            end
            K_SEEK: begin
                // seek past the block end lands on the end
                n_pos = (i_q_ent.arg > 32'(e_size)) ? e_size : i_q_ent.arg[SW-1:0];
            end
            K_BLKCL: begin
                n_size = '0;
                n_pos  = '0;
            end
            K_DATA: begin
                if (e_size < DEPTH_W) begin
                    we     = 1'b1;
                    n_size = e_size + SW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && we) begin
            r_pcm[waddr] <= wdata;
        end
        if (o_pop && re) begin
            r_rd <= r_pcm[raddr];
        end
    end

    always_comb begin
        o_res = r_p_res;
        if (r_p_mem) begin
            o_res.reg_value = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= '0;
            r_pos     <= '0;
            r_p_valid <= 1'b0;
            r_p_mem   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_size    <= n_size;
                r_pos     <= n_pos;
                r_p_valid <= p_load;
                r_p_mem   <= re;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_res <= p_res;
        end
        if (p_move) begin
            r_o_res <= o_res;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_res;

    a_pos_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_size)
        else $error("pcm read position beyond block size");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= DEPTH_W)
        else $error("pcm block size beyond memory depth");

    a_mem_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && r_p_mem) |-> (r_p_res.has_write && r_p_res.reg_addr == REG_PCM_DATA))
        else $error("pcm read pending without a pcm register write");

endmodule

@@ bench/vgm_stream_checker.sv @@
`timescale 1ns / 100ps
// request and result monitor for vgm_command_stream_parser: predicts each result
// from the accepted stream bytes and compares it field by field; depends on vcsp_pkg
module vgm_stream_checker
    import vcsp_pkg::*;
#(
    parameter int PCM_DEPTH = 65536
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending
);

    typedef enum logic [1:0] {P_COMMAND, P_OPERANDS, P_DATA} t_parse_phase;

    t_parse_phase phase;
    logic [7:0]   cur_cmd;
    int unsigned  op_cnt;
    logic [31:0]  op_acc;
    int unsigned  blk_size;
    int unsigned  rd_pos;
    logic         halted;
    logic [7:0]   pcm_bytes [PCM_DEPTH];
    t_out         due_results [$];
    int           mismatches;

    function automatic int operand_bytes(input logic [7:0] cmd);
        if (cmd == CMD_WRITE_P0 || cmd == CMD_WRITE_P1 || cmd == CMD_WAIT_N) return 2;
        if (cmd == CMD_SEEK) return 4;
        if (cmd == CMD_DATA_BLOCK) return 6;
        return 0;
    endfunction

    task automatic restart_stream();
        phase    = P_COMMAND;
        cur_cmd  = '0;
        op_cnt   = 0;
        op_acc   = '0;
        blk_size = 0;
        rd_pos   = 0;
        halted   = 1'b0;
    endtask

    task automatic parse_stream_byte(input t_in req);
        t_out       res;
        logic       emit;
        logic [7:0] b;
        b    = req.stream_byte;
        res  = '0;
        emit = 1'b0;
        if (req.start_of_stream) restart_stream();
        if (!halted) begin
            case (phase)
                P_COMMAND: begin
                    cur_cmd = b;
                    op_cnt  = 0;
                    op_acc  = '0;
                    if (operand_bytes(b) != 0) begin
                        phase = P_OPERANDS;
                    end else if (b == CMD_END) begin
                        res.stream_end = 1'b1;
                        halted = 1'b1;
                        emit = 1'b1;
                    end else if (b[7:4] == GRP_WAIT_SHORT) begin
                        res.wait_samples = 16'(b[3:0]) + 16'd1;
                        emit = 1'b1;
                    end else if (b[7:4] == GRP_PCM_SEND) begin
                        if (rd_pos < blk_size) begin
                            res.has_write = 1'b1;
                            res.reg_addr  = REG_PCM_DATA;
                            res.reg_value = pcm_bytes[rd_pos];
                            rd_pos++;
                        end
                        res.wait_samples = 16'(b[3:0]);
                        emit = 1'b1;
                    end else begin
                        res.bad_command = 1'b1;
                        halted = 1'b1;
                        emit = 1'b1;
                    end
                end
                P_OPERANDS: begin
                    // data block: marker and type byte are skipped, size follows
                    if (cur_cmd == CMD_DATA_BLOCK) begin
                        if (op_cnt >= 2) op_acc |= 32'(b) << (8 * ((op_cnt - 2) % 4));
                    end else begin
                        op_acc |= 32'(b) << (8 * (op_cnt % 4));
                    end
                    op_cnt = (op_cnt + 1) % 8;
                    if (op_cnt >= operand_bytes(cur_cmd)) begin
                        phase = P_COMMAND;
                        if (cur_cmd == CMD_WRITE_P0 || cur_cmd == CMD_WRITE_P1) begin
                            res.has_write = 1'b1;
                            res.port      = cur_cmd[0];
                            res.reg_addr  = op_acc[7:0];
                            res.reg_value = op_acc[15:8];
                            emit = 1'b1;
                        end else if (cur_cmd == CMD_WAIT_N) begin
                            res.wait_samples = op_acc[15:0];
                            emit = 1'b1;
                        end else if (cur_cmd == CMD_SEEK) begin
                            rd_pos = (op_acc > blk_size) ? blk_size : op_acc;
                        end else begin
                            blk_size = 0;
                            rd_pos   = 0;
                            if (op_acc != 0) phase = P_DATA;
                        end
                        op_cnt = 0;
                    end
                end
                default: begin
                    // bytes past the memory depth are dropped
                    if (blk_size < PCM_DEPTH) begin
                        pcm_bytes[blk_size] = b;
                        blk_size++;
                    end
                    op_acc--;
                    if (op_acc == 0) phase = P_COMMAND;
                end
            endcase
        end
        if (emit) due_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            restart_stream();
            due_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no request waiting for it");
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("has_write", want.has_write, i_out_data.has_write);
                    check_field("port", want.port, i_out_data.port);
                    check_field("reg_addr", want.reg_addr, i_out_data.reg_addr);
                    check_field("reg_value", want.reg_value, i_out_data.reg_value);
                    check_field("wait_samples", want.wait_samples, i_out_data.wait_samples);
                    check_field("stream_end", want.stream_end, i_out_data.stream_end);
                    check_field("bad_command", want.bad_command, i_out_data.bad_command);
                end
            end
            if (i_in_valid && i_in_ready) parse_stream_byte(i_in_data);
        end
        o_errors  <= mismatches;
        o_pending <= due_results.size();
    end

endmodule

@@ bench/tb_vgm_command_stream_parser.sv @@
`timescale 1ns / 100ps
// top of the vgm_command_stream_parser bench: clock, reset, byte stream requests,
// result receiver with random stalls and verdict; depends on vcsp_pkg and vgm_stream_checker
module tb_vgm_command_stream_parser;
    import vcsp_pkg::*;

    // small memory, so oversized blocks stay cheap
    localparam int PCM_DEPTH      = 256;
    localparam int REQUEST_TARGET = 1700;
    localparam int IDLE_LIMIT     = 2000;

    logic clk;
    logic rst_n;
    logic in_valid;
    t_in  in_data;
    logic in_ready;
    logic out_valid;
    t_out out_data;
    logic out_ready;
    int   errors;
    int   pending;
    int   idle_cycles;
    int   rx_stall;
    int   sent_count;
    logic sos_next;       // next request carries start_of_stream
    logic stream_halted;  // bytes sent now are dropped by the block
    logic tx_quiet;       // stretch of back-to-back requests
    logic rx_quiet;       // stretch with the receiver always ready

    vgm_command_stream_parser #(
        .PCM_DEPTH(PCM_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .i_data (in_data),
        .o_ready(in_ready),
        .o_valid(out_valid),
        .o_data (out_data),
        .i_ready(out_ready)
    );

    vgm_stream_checker #(
        .PCM_DEPTH(PCM_DEPTH)
    ) checker_i (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: after each accepted result draw a random stall, none in quiet stretches,
    // and now and then drop ready while nothing is offered
    always @(posedge clk) begin : receiver
        int stall;
        if (!rst_n) begin
            out_ready <= 1'b1;
            rx_stall  <= 0;
            rx_quiet  <= 1'b0;
        end else if (rx_stall != 0) begin
            if (rx_stall == 1) out_ready <= 1'b1;
            rx_stall <= rx_stall - 1;
        end else if (out_valid && out_ready) begin
            if ($urandom_range(0, 63) == 0) rx_quiet <= ~rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                out_ready <= 1'b0;
                rx_stall  <= stall;
            end
        end else if (!out_valid && !rx_quiet && $urandom_range(0, 15) == 0) begin
            out_ready <= 1'b0;
            rx_stall  <= $urandom_range(1, 11);
        end
    end

    // watchdog: too long with no request and no result taken
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("[vgm_command_stream_parser] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one stream byte request; random gap before it, none in quiet stretches, valid held until taken
    task automatic put_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 59) == 0) tx_quiet = ~tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid                <= 1'b1;
        in_data.stream_byte     <= b;
        in_data.start_of_stream <= sos_next;
        if (sos_next) stream_halted = 1'b0;
        if (!stream_halted) sent_count++;
        sos_next = 1'b0;
        do @(posedge clk); while (!in_ready);
    endtask

    // data block header with a little-endian size, then the first 'count' data bytes
    task automatic put_block(input int unsigned size, input int unsigned count);
        put_byte(CMD_DATA_BLOCK);
        // the marker byte is not checked by the block, so sometimes it is junk
        put_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : CMD_END);
        put_byte(8'($urandom));
        for (int i = 0; i < 4; i++) put_byte(size[8*i +: 8]);
        repeat (count) put_byte(8'($urandom));
    endtask

    task automatic random_command();
        int          pick;
        int unsigned size;
        int unsigned offset;
        logic [7:0]  junk;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            put_byte($urandom_range(0, 1) ? CMD_WRITE_P1 : CMD_WRITE_P0);
            put_byte(8'($urandom));
            put_byte(8'($urandom));
        end else if (pick < 27) begin
            put_byte(CMD_WAIT_N);
            put_byte(8'($urandom));
            put_byte(8'($urandom));
        end else if (pick < 36) begin
            put_byte({GRP_WAIT_SHORT, 4'($urandom)});
        end else if (pick < 56) begin
            put_byte({GRP_PCM_SEND, 4'($urandom)});
        end else if (pick < 66) begin
            // mostly short blocks, some empty, a few around the memory depth
            case ($urandom_range(0, 19))
                0, 1, 2: size = 0;
                3:       size = PCM_DEPTH - 2 + $urandom_range(0, 4);
                default: size = $urandom_range(1, 24);
            endcase
            put_block(size, size);
        end else if (pick < 76) begin
            // seek inside the block or far past it
            offset = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32);
            put_byte(CMD_SEEK);
            for (int i = 0; i < 4; i++) put_byte(offset[8*i +: 8]);
        end else if (pick < 82) begin
            if (pick < 79) begin
                put_byte(CMD_END);
            end else begin
                do junk = 8'($urandom);
                while (junk == CMD_WRITE_P0 || junk == CMD_WRITE_P1 || junk == CMD_WAIT_N ||
                       junk == CMD_END || junk == CMD_DATA_BLOCK || junk == CMD_SEEK ||
                       junk[7:4] == GRP_WAIT_SHORT || junk[7:4] == GRP_PCM_SEND);
                put_byte(junk);
            end
            // halted: a few dropped bytes, then a new stream
            stream_halted = 1'b1;
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
            sos_next = 1'b1;
        end else if (pick < 88) begin
            sos_next = 1'b1;
        end else if (pick < 93) begin
            // command cut short by a restart
            case ($urandom_range(0, 3))
                0: begin
                    put_byte(CMD_WRITE_P0);
                    repeat ($urandom_range(0, 1)) put_byte(8'($urandom));
                end
                1: begin
                    put_byte(CMD_WAIT_N);
                    repeat ($urandom_range(0, 1)) put_byte(8'($urandom));
                end
                2: begin
                    put_byte(CMD_SEEK);
                    repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
                end
                default: begin
                    size = $urandom_range(2, 24);
                    put_block(size, $urandom_range(0, size - 1));
                end
            endcase
            sos_next = 1'b1;
        end else begin
            // noise byte, may throw the parser out of step until the next restart
            put_byte(8'($urandom));
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        sent_count    = 0;
        sos_next      = 1'b0;
        stream_halted = 1'b0;
        tx_quiet      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: register writes at the byte extremes on both ports
        sos_next = 1'b1;
        put_byte(CMD_WRITE_P0);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CMD_WRITE_P1);
        put_byte(8'hFF);
        put_byte(8'h00);
        // longest long wait, shortest and longest short wait
        put_byte(CMD_WAIT_N);
        put_byte(8'hFF);
        put_byte(8'hFF);
        put_byte({GRP_WAIT_SHORT, 4'h0});
        put_byte({GRP_WAIT_SHORT, 4'hF});
        // pcm send with no block loaded
        put_byte({GRP_PCM_SEND, 4'h0});
        // one-byte block, sent once, then a send with nothing left
        put_byte(CMD_DATA_BLOCK);
        put_byte(CMD_END);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'hA5);
        put_byte({GRP_PCM_SEND, 4'hF});
        put_byte({GRP_PCM_SEND, 4'h0});
        // unknown command halts; the byte after it is dropped
        put_byte(8'h00);
        stream_halted = 1'b1;
        put_byte(CMD_WRITE_P0);
        // fresh stream that ends at once, then a dropped byte
        sos_next = 1'b1;
        put_byte(CMD_END);
        stream_halted = 1'b1;
        put_byte(8'hFF);

        // random: mostly well-formed commands with random content
        sos_next = 1'b1;
        while (sent_count < REQUEST_TARGET) random_command();
        in_valid <= 1'b0;

        // drain, then keep watching to catch stray results
        @(posedge clk);
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("[vgm_command_stream_parser] OK");
        end else begin
            $display("[vgm_command_stream_parser] ERROR");
        end
        $finish;
    end

endmodule
